[rtl/tdpt_pkg.sv]
// Package: shared constants for the trial-division prime test.
`default_nettype none
package tdpt_pkg;

	// Default operand width of the number under test
	localparam int unsigned WIDTH_DEFAULT = 32;

	// First trial divisor
	localparam int unsigned FIRST_DIVISOR = 2;

endpackage
`default_nettype wire

[rtl/tdpt_div.sv]
// Module: bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module tdpt_div
	import tdpt_pkg::*;
#(
	parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] num,
	input  wire logic [WIDTH-1:0] den,
	output logic                  done,
	output logic      [WIDTH-1:0] quo,
	output logic      [WIDTH-1:0] rem
);

	localparam int unsigned CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;
	logic             ge;
	logic [WIDTH-1:0] rem_next;
	logic [WIDTH-1:0] quo_next;

	// Shift in the next dividend bit and try to subtract the divisor
	always_comb begin
		shifted  = {rem_q, quo_q[WIDTH-1]};
		diff     = shifted - {1'b0, den_q};
		ge       = (shifted >= {1'b0, den_q});
		rem_next = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
		quo_next = {quo_q[WIDTH-2:0], ge};
	end

	// Sequence the steps: load on start, advance while busy, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(WIDTH);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Hold the datapath words
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

[rtl/trial_division_prime_test_top.sv]
// Module: trial-division primality test, top level with valid/stall channels.
//
// Usage:
//   Input channel: number with in_valid; the block drives in_stall. A beat is
//   taken when in_valid is high and in_stall is low. in_stall is low only while
//   the block is idle, so one number is worked on at a time.
//   Output channel: is_prime and below_two with out_valid; the receiver drives
//   out_stall. The result register holds its beat until it is taken, and the
//   block may accept the next number while that beat still waits.
//   A number below two goes straight to the finish state. Any
//   other number runs trial divisors d = 2, 3, ... on one shared bit-serial
//   divider; each divisor takes one load, WIDTH quotient bits and one check.
//   The test stops at the first zero remainder or when d exceeds number / d.
//   Reset (arst_n low, asynchronous) drops any work in progress and any
//   pending result; the block comes up idle with out_valid low.
//   While the result register is full and stalled, a finished test waits in
//   place and the input stays stalled.
`default_nettype none
module trial_division_prime_test_top
	import tdpt_pkg::*;
#(
	parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [WIDTH-1:0] number,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  is_prime,
	output logic                  below_two
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_START  = 2'd1;
	localparam logic [1:0] ST_WAIT   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]       state_q;
	logic [WIDTH-1:0] number_q;
	logic [WIDTH-1:0] div_q;
	logic             res_prime_q;
	logic             res_below_q;
	logic             out_valid_q;
	logic             is_prime_q;
	logic             below_two_q;

	logic             in_take;
	logic             out_take;
	logic             out_load;
	logic             div_start;
	logic             div_done;
	logic [WIDTH-1:0] div_quo;
	logic [WIDTH-1:0] div_rem;

	assign in_take   = in_valid && (state_q == ST_IDLE);
	assign out_take  = out_valid_q && !out_stall;
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign div_start = (state_q == ST_START);

	tdpt_div #(
		.WIDTH(WIDTH)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (number_q),
		.den   (div_q),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	// Sequence one test: accept, loop over divisors, hand the result on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (number < WIDTH'(FIRST_DIVISOR)) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						if ((div_q > div_quo) || (div_rem == '0)) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the number, the trial divisor and the verdict
	always_ff @(posedge clk) begin
		if (in_take) begin
			number_q    <= number;
			div_q       <= WIDTH'(FIRST_DIVISOR);
			res_prime_q <= 1'b0;
			res_below_q <= (number < WIDTH'(FIRST_DIVISOR));
		end else if ((state_q == ST_WAIT) && div_done) begin
			if (div_q > div_quo) begin
				res_prime_q <= 1'b1;
			end else if (div_rem == '0) begin
				res_prime_q <= 1'b0;
			end else begin
				div_q <= div_q + WIDTH'(1);
			end
		end
	end

	// Track the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			is_prime_q  <= res_prime_q;
			below_two_q <= res_below_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;
	assign below_two = below_two_q;

endmodule
`default_nettype wire
